// File: src/tlvp_pkg.sv
// Types and codes shared by the header/TLV message parser.
// No dependencies; compile first.
package tlvp_pkg;

    // Parse phase, one-hot
    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_RECHDR = 4'b0010,
        PH_VALUE  = 4'b0100,
        PH_TRAIL  = 4'b1000
    } t_phase;

    // Result event codes
    typedef enum logic [2:0] {
        EV_HEADER_DONE  = 3'd0,
        EV_RECORD_START = 3'd1,
        EV_VALUE_BYTE   = 3'd2,
        EV_MSG_OK       = 3'd3,
        EV_MSG_ERROR    = 3'd4
    } t_event;

    // Final status error codes
    typedef enum logic [1:0] {
        ERR_NONE            = 2'd0,
        ERR_SHORT_HEADER    = 2'd1,
        ERR_TRUNC_RECORD_HDR = 2'd2,
        ERR_TRUNC_VALUE     = 2'd3
    } t_error;

    // Header byte position of the last header byte
    localparam logic [2:0] HDR_LAST_BYTE = 3'd7;

    // One result item
    typedef struct packed {
        t_event      event_res;
        logic [15:0] msg_id;
        logic [7:0]  msg_type;
        logic [7:0]  msg_status;
        logic [31:0] record_total;
        logic [31:0] record_index;
        logic [7:0]  record_type;
        logic [15:0] record_length;
        logic [7:0]  value_data;
        logic [15:0] value_offset;
        t_error      error_code;
        logic        last;
    } t_result;

    // Results of one input item, handed from parser to result queue
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

// File: src/tlvp_ifs.sv
// Valid/ready channel interfaces for message bytes and result items.
// Depends on tlvp_pkg.
interface tlvp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface tlvp_out_if import tlvp_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: src/tlvp_parse.sv
// Parser state and per-byte next-state/result logic.
// Depends on tlvp_pkg.
module tlvp_parse import tlvp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_eom,
    input  logic       i_room,
    output logic       o_take,
    output t_push      o_push
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_bp, n_bp;
    logic [15:0] r_id, n_id;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_status, n_status;
    logic [31:0] r_ann, n_ann;
    logic [31:0] r_done, n_done;
    logic [7:0]  r_rtype, n_rtype;
    logic [15:0] r_rlen, n_rlen;
    logic [15:0] r_vpos, n_vpos;

    logic        ev0_valid;
    t_event      ev0;
    logic [7:0]  v_data;
    logic [15:0] v_off;
    logic        finish;
    logic [15:0] vpos_inc;
    logic [31:0] done_inc;
    t_error      fin_err;
    t_result     res0, res1;

    assign o_take   = i_valid && i_room;
    assign vpos_inc = r_vpos + 16'd1;
    assign done_inc = r_done + 32'd1;

    // Field update and byte event
    always_comb begin
        n_phase   = r_phase;
        n_bp      = r_bp;
        n_id      = r_id;
        n_type    = r_type;
        n_status  = r_status;
        n_ann     = r_ann;
        n_done    = r_done;
        n_rtype   = r_rtype;
        n_rlen    = r_rlen;
        n_vpos    = r_vpos;
        ev0_valid = 1'b0;
        ev0       = EV_HEADER_DONE;
        v_data    = 8'd0;
        v_off     = 16'd0;
        finish    = 1'b0;
        unique case (r_phase)
            PH_HEADER: begin
                unique case (r_bp)
                    3'd0: n_id = {i_byte, r_id[7:0]};
                    3'd1: n_id = {r_id[15:8], i_byte};
                    3'd2: n_type = i_byte;
                    3'd3: n_status = i_byte;
                    3'd4: n_ann = {i_byte, r_ann[23:0]};
                    3'd5: n_ann = {r_ann[31:24], i_byte, r_ann[15:0]};
                    3'd6: n_ann = {r_ann[31:16], i_byte, r_ann[7:0]};
                    default: n_ann = {r_ann[31:8], i_byte};
                endcase
                if (r_bp == HDR_LAST_BYTE) begin
                    n_bp      = 3'd0;
                    n_phase   = (n_ann == 32'd0) ? PH_TRAIL : PH_RECHDR;
                    ev0_valid = 1'b1;
                    ev0       = EV_HEADER_DONE;
                end else begin
                    n_bp = r_bp + 3'd1;
                end
            end
            PH_RECHDR: begin
                priority if (r_bp == 3'd0) begin
                    n_rtype = i_byte;
                    n_rlen  = 16'd0;
                    n_bp    = 3'd1;
                end else if (r_bp == 3'd1) begin
                    n_rlen = {i_byte, 8'd0};
                    n_bp   = 3'd2;
                end else begin
                    n_rlen    = {r_rlen[15:8], i_byte};
                    n_vpos    = 16'd0;
                    ev0_valid = 1'b1;
                    ev0       = EV_RECORD_START;
                    if (n_rlen == 16'd0) begin
                        finish = 1'b1;
                    end else begin
                        n_bp    = 3'd0;
                        n_phase = PH_VALUE;
                    end
                end
            end
            PH_VALUE: begin
                ev0_valid = 1'b1;
                ev0       = EV_VALUE_BYTE;
                v_data    = i_byte;
                v_off     = r_vpos;
                if (vpos_inc == r_rlen) begin
                    n_vpos = 16'd0;
                    finish = 1'b1;
                end else begin
                    n_vpos = vpos_inc;
                end
            end
            PH_TRAIL: begin
            end
            default: begin
            end
        endcase
        // Close the record and pick the next phase
        if (finish) begin
            n_done  = done_inc;
            n_bp    = 3'd0;
            n_phase = (done_inc == n_ann) ? PH_TRAIL : PH_RECHDR;
        end
    end

    // Final status from the phase left after this byte
    always_comb begin
        unique case (n_phase)
            PH_HEADER: fin_err = ERR_SHORT_HEADER;
            PH_RECHDR: fin_err = ERR_TRUNC_RECORD_HDR;
            PH_VALUE:  fin_err = ERR_TRUNC_VALUE;
            default:   fin_err = ERR_NONE;
        endcase
    end

    // Build the result items
    always_comb begin
        res0.event_res     = ev0;
        res0.msg_id        = n_id;
        res0.msg_type      = n_type;
        res0.msg_status    = n_status;
        res0.record_total  = n_ann;
        res0.record_index  = r_done;
        res0.record_type   = n_rtype;
        res0.record_length = n_rlen;
        res0.value_data    = v_data;
        res0.value_offset  = v_off;
        res0.error_code    = ERR_NONE;
        res0.last          = !i_eom;

        res1               = res0;
        res1.event_res     = (fin_err == ERR_NONE) ? EV_MSG_OK : EV_MSG_ERROR;
        res1.record_index  = n_done;
        res1.value_data    = 8'd0;
        res1.value_offset  = 16'd0;
        res1.error_code    = fin_err;
        res1.last          = 1'b1;

        o_push.count  = o_take ? ({1'b0, ev0_valid} + {1'b0, i_eom}) : 2'd0;
        o_push.first  = ev0_valid ? res0 : res1;
        o_push.second = res1;
    end

    // Advance state; end of message returns to reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_take && i_eom)) begin
            r_phase  <= PH_HEADER;
            r_bp     <= 3'd0;
            r_id     <= 16'd0;
            r_type   <= 8'd0;
            r_status <= 8'd0;
            r_ann    <= 32'd0;
            r_done   <= 32'd0;
            r_rtype  <= 8'd0;
            r_rlen   <= 16'd0;
            r_vpos   <= 16'd0;
        end else if (o_take) begin
            r_phase  <= n_phase;
            r_bp     <= n_bp;
            r_id     <= n_id;
            r_type   <= n_type;
            r_status <= n_status;
            r_ann    <= n_ann;
            r_done   <= n_done;
            r_rtype  <= n_rtype;
            r_rlen   <= n_rlen;
            r_vpos   <= n_vpos;
        end
    end

`ifndef SYNTHESIS
    a_eom_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_eom) |=> (r_phase == PH_HEADER && r_bp == 3'd0 && r_done == 32'd0))
        else $error("parser did not restart after end of message");
    a_value_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_VALUE) |-> (r_vpos < r_rlen))
        else $error("value offset past record length");
    a_records: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RECHDR || r_phase == PH_VALUE) |-> (r_done < r_ann))
        else $error("record count overrun");
`endif

endmodule

// File: src/tlvp_result_queue.sv
// Four-entry result queue: takes up to two items a cycle, gives one when the output is ready.
// Depends on tlvp_pkg and tlvp_out_if.
module tlvp_result_queue import tlvp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_push       i_push,
    output logic        o_room,
    tlvp_out_if.source  o_res
);

    localparam int DEPTH = 4;

    t_result    r_mem [DEPTH];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_count, n_count;
    logic       pop;

    assign o_room        = r_count <= 3'(DEPTH - 2);
    assign o_res.valid   = r_count != 3'd0;
    assign o_res.payload = r_mem[r_rd];
    assign pop           = o_res.valid && o_res.ready;
    assign n_count       = r_count + {1'b0, i_push.count} - {2'b0, pop};

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_push.second;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 2'd0;
            r_rd    <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wr    <= r_wr + i_push.count;
            r_rd    <= r_rd + {1'b0, pop};
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> ({1'b0, r_count} + {2'b0, i_push.count} <= 4'(DEPTH)))
        else $error("result queue overflow");
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(DEPTH))
        else $error("result queue count out of range");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_count == 3'd0))
        else $error("result queue not empty after reset");
`endif

endmodule

// File: src/header_tlv_message_parser.sv
// Top level of the header/TLV message parser: input register, parser, result queue.
// Depends on tlvp_pkg, tlvp_ifs, tlvp_parse, tlvp_result_queue.

// Takes one message byte per cycle while the result queue has room: an 8-byte
// big-endian header (id, type, status, 32-bit record count) followed by that many
// type/length/value records, and gives header-done, record-start and value-byte events
// plus a final ok/error status on the byte flagged end of message, after which the
// parser starts a new message. Each byte gives zero, one or two results; results leave
// through a four-entry queue at one per cycle while the output is ready, so the sustained
// rate is one byte per cycle except that a byte giving two results (an end-of-message
// byte that also has its own event) takes longer to drain. A byte passes through the
// input register and then a queue entry before its first result is offered.
module header_tlv_message_parser import tlvp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlvp_in_if.sink     i_in,
    tlvp_out_if.source  o_res
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eom;
    logic       take;
    logic       room;
    t_push      push;

    assign i_in.ready = !r_in_valid || take;

    // Hold the accepted byte until the parser takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_eom  <= i_in.end_of_message;
        end
    end

    tlvp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_byte  (r_in_byte),
        .i_eom   (r_in_eom),
        .i_room  (room),
        .o_take  (take),
        .o_push  (push)
    );

    tlvp_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_res   (o_res)
    );

endmodule
